### hw/rtl/psm_pkg.sv
// psm_pkg: opcodes, sub-operation codes, error codes and sequencer states
// of the p-code stack machine core
// no dependencies
package psm_pkg;

    // address arithmetic width: 32-bit operand plus an unsigned 32-bit base
    localparam int AW = 34;

    typedef enum logic [3:0] {
        OP_LIT = 4'd0,
        OP_OPR = 4'd1,
        OP_LOD = 4'd2,
        OP_STO = 4'd3,
        OP_CAL = 4'd4,
        OP_INT = 4'd5,
        OP_JMP = 4'd6,
        OP_JPC = 4'd7,
        OP_CSP = 4'd8,
        OP_RET = 4'd9
    } op_t;

    // OPR sub-operations
    localparam logic signed [31:0] OPR_RET = 32'sd0;
    localparam logic signed [31:0] OPR_NEG = 32'sd1;
    localparam logic signed [31:0] OPR_ADD = 32'sd2;
    localparam logic signed [31:0] OPR_SUB = 32'sd3;
    localparam logic signed [31:0] OPR_MUL = 32'sd4;
    localparam logic signed [31:0] OPR_DIV = 32'sd5;
    localparam logic signed [31:0] OPR_ODD = 32'sd6;
    localparam logic signed [31:0] OPR_EQ  = 32'sd7;
    localparam logic signed [31:0] OPR_NE  = 32'sd8;
    localparam logic signed [31:0] OPR_LT  = 32'sd9;
    localparam logic signed [31:0] OPR_GE  = 32'sd10;
    localparam logic signed [31:0] OPR_GT  = 32'sd11;
    localparam logic signed [31:0] OPR_LE  = 32'sd12;

    // CSP sub-operations
    localparam logic signed [31:0] CSP_READ    = 32'sd0;
    localparam logic signed [31:0] CSP_WRITE   = 32'sd1;
    localparam logic signed [31:0] CSP_WRITELN = 32'sd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_STACK = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;

    typedef enum logic [21:0] {
        ST_CLEAR  = 22'h000001,
        ST_IDLE   = 22'h000002,
        ST_DECODE = 22'h000004,
        ST_WALK   = 22'h000008,
        ST_WALK_W = 22'h000010,
        ST_ADDR   = 22'h000020,
        ST_LOD_W  = 22'h000040,
        ST_STO_W  = 22'h000080,
        ST_CAL2   = 22'h000100,
        ST_CAL3   = 22'h000200,
        ST_JPC_W  = 22'h000400,
        ST_MOD    = 22'h000800,
        ST_DIVIDE = 22'h001000,
        ST_RN_NB  = 22'h002000,
        ST_RN_PC  = 22'h004000,
        ST_RT_TMP = 22'h008000,
        ST_AR_Y   = 22'h010000,
        ST_AR_X   = 22'h020000,
        ST_UN_W   = 22'h040000,
        ST_CS_W   = 22'h080000,
        ST_FIN    = 22'h100000,
        ST_MOD2   = 22'h200000
    } state_t;

endpackage

### hw/rtl/pcode_stack_machine_core.sv
// pcode_stack_machine_core: executes one p-code instruction per request on
// a stack held in a synchronous memory; uses psm_pkg
//
// Each request is the instruction at the current pc; one result with the next
// pc follows it. The stack lives in a single memory with one write and one
// registered read per cycle, and an instruction runs as a sequence of read,
// modify and write steps on it; LOD, STO and CAL add a static link read for
// each level walked, and DIV runs through the serial divider. When CODE_DEPTH
// is not a power of two, every jump target and return address is reduced by a
// reciprocal multiplication in an extra step. After reset the block clears the
// stack memory, one word a cycle, before it takes its first request. A
// finished result waits in an output register while the next request is
// already taken.
module pcode_stack_machine_core #(
    parameter int STACK_DEPTH = 512,
    parameter int CODE_DEPTH  = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_operation,
    input  logic [3:0]                    s_level,
    input  logic signed [31:0]            s_operand,
    input  logic signed [31:0]            s_read_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [$clog2(CODE_DEPTH)-1:0] m_next_pc,
    output logic                          m_write_valid,
    output logic signed [31:0]            m_write_value,
    output logic                          m_newline,
    output logic                          m_halted,
    output logic [1:0]                    m_error_code
);
    import psm_pkg::*;

    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int PCW = $clog2(CODE_DEPTH);
    localparam bit CODE_POW2 = ((CODE_DEPTH & (CODE_DEPTH - 1)) == 0);
    localparam logic signed [AW-1:0] STK_LIM = AW'(STACK_DEPTH);
    localparam logic [31:0] CODE_DEN = 32'(CODE_DEPTH);
    localparam logic [31:0] CODE_RCP = 32'(64'h1_0000_0000 / 64'(CODE_DEPTH));

    // stack memory
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;
    logic        mem_we, mem_re;
    logic [SW-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_ra];
        end
    end

    // control registers
    state_t        state_reg, state_next;
    logic [SW-1:0] t_reg, t_next;
    logic [SW-1:0] b_reg, b_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic          m_valid_reg, m_valid_next;
    logic [SW-1:0] clr_cnt_reg, clr_cnt_next;

    // request and working registers
    logic [3:0]         op_reg, op_next;
    logic [3:0]         lv_reg, lv_next;
    logic signed [31:0] opa_reg, opa_next;
    logic [31:0]        rv_reg, rv_next;
    logic [SW-1:0]      nt_reg, nt_next;
    logic [SW-1:0]      nb_reg, nb_next;
    logic [PCW-1:0]     np_reg, np_next;
    logic [1:0]         err_reg, err_next;
    logic               wv_reg, wv_next;
    logic [31:0]        wval_reg, wval_next;
    logic               nl_reg, nl_next;
    logic [31:0]        base_reg, base_next;
    logic [SW-1:0]      addr_reg, addr_next;
    logic [31:0]        d0_reg, d0_next;
    logic [31:0]        mod_src_reg, mod_src_next;
    logic [31:0]        mq_reg, mq_next;

    // serial divider
    logic [32:0] dv_rem_reg, dv_rem_next;
    logic [31:0] dv_quo_reg, dv_quo_next;
    logic [31:0] dv_den_reg, dv_den_next;
    logic [4:0]  dv_cnt_reg, dv_cnt_next;
    logic        dv_neg_reg, dv_neg_next;

    // output registers
    logic [PCW-1:0] o_pc_reg, o_pc_next;
    logic           o_wv_reg, o_wv_next;
    logic [31:0]    o_wval_reg, o_wval_next;
    logic           o_nl_reg, o_nl_next;
    logic [1:0]     o_err_reg, o_err_next;

    // stack address arithmetic
    logic signed [AW-1:0] t_s, b_s, a_s, base_s, rd_s;
    logic signed [AW-1:0] t_p1, t_p2, t_p3, t_m1, t_pa, b_m1, b_p1, b_p2, b_ma, addr_s;
    logic [PCW-1:0] pc_inc;

    assign t_s    = $signed({{(AW-SW){1'b0}}, t_reg});
    assign b_s    = $signed({{(AW-SW){1'b0}}, b_reg});
    assign a_s    = $signed({{(AW-32){opa_reg[31]}}, opa_reg});
    assign base_s = $signed({{(AW-32){1'b0}}, base_reg});
    assign rd_s   = $signed({{(AW-32){1'b0}}, rd_data_reg});
    assign t_p1   = t_s + AW'(1);
    assign t_p2   = t_s + AW'(2);
    assign t_p3   = t_s + AW'(3);
    assign t_m1   = t_s - AW'(1);
    assign t_pa   = t_s + a_s;
    assign b_m1   = b_s - AW'(1);
    assign b_p1   = b_s + AW'(1);
    assign b_p2   = b_s + AW'(2);
    assign b_ma   = b_s - a_s;
    assign addr_s = base_s + a_s;
    assign pc_inc = (pc_reg == PCW'(CODE_DEPTH - 1)) ? '0 : pc_reg + PCW'(1);

    function automatic logic in_stk(input logic signed [AW-1:0] x);
        return (x >= 0) && (x < STK_LIM);
    endfunction

    // divider step
    logic [32:0] dv_sh, dv_sub;
    logic        dv_ge;
    logic [31:0] dv_q_fin;
    assign dv_sh    = {dv_rem_reg[31:0], dv_quo_reg[31]};
    assign dv_sub   = dv_sh - {1'b0, dv_den_reg};
    assign dv_ge    = (dv_sh >= {1'b0, dv_den_reg});
    assign dv_q_fin = {dv_quo_reg[30:0], dv_ge};

    // target modulo code depth: reciprocal estimate, then one correction
    logic [63:0] mod_prod;
    logic [31:0] mod_rem, mod_fix;
    assign mod_prod = {32'd0, mod_src_reg} * {32'd0, CODE_RCP};
    assign mod_rem  = mod_src_reg - mq_reg * CODE_DEN;
    assign mod_fix  = (mod_rem >= CODE_DEN) ? (mod_rem - CODE_DEN) : mod_rem;

    // arithmetic and compare on the two top words
    logic [31:0]        ar_x, ar_y, ar_res, x_abs, y_abs;
    logic signed [31:0] xs, ys;
    assign ar_x  = rd_data_reg;
    assign ar_y  = d0_reg;
    assign xs    = $signed(ar_x);
    assign ys    = $signed(ar_y);
    assign x_abs = ar_x[31] ? (32'd0 - ar_x) : ar_x;
    assign y_abs = ar_y[31] ? (32'd0 - ar_y) : ar_y;

    always_comb begin
        case (opa_reg)
            OPR_ADD: ar_res = ar_x + ar_y;
            OPR_SUB: ar_res = ar_x - ar_y;
            OPR_MUL: ar_res = ar_x * ar_y;
            OPR_EQ:  ar_res = {31'd0, xs == ys};
            OPR_NE:  ar_res = {31'd0, xs != ys};
            OPR_LT:  ar_res = {31'd0, xs < ys};
            OPR_GE:  ar_res = {31'd0, xs >= ys};
            OPR_GT:  ar_res = {31'd0, xs > ys};
            default: ar_res = {31'd0, xs <= ys};
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        t_next       = t_reg;
        b_next       = b_reg;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        clr_cnt_next = clr_cnt_reg;
        op_next      = op_reg;
        lv_next      = lv_reg;
        opa_next     = opa_reg;
        rv_next      = rv_reg;
        nt_next      = nt_reg;
        nb_next      = nb_reg;
        np_next      = np_reg;
        err_next     = err_reg;
        wv_next      = wv_reg;
        wval_next    = wval_reg;
        nl_next      = nl_reg;
        base_next    = base_reg;
        addr_next    = addr_reg;
        d0_next      = d0_reg;
        mod_src_next = mod_src_reg;
        mq_next      = mq_reg;
        dv_rem_next  = dv_rem_reg;
        dv_quo_next  = dv_quo_reg;
        dv_den_next  = dv_den_reg;
        dv_cnt_next  = dv_cnt_reg;
        dv_neg_next  = dv_neg_reg;
        o_pc_next    = o_pc_reg;
        o_wv_next    = o_wv_reg;
        o_wval_next  = o_wval_reg;
        o_nl_next    = o_nl_reg;
        o_err_next   = o_err_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = '0;
        mem_ra = '0;
        mem_wd = '0;

        case (state_reg)
            // zero the stack after reset
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SW'(1);
                if (clr_cnt_reg == SW'(STACK_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            // take a request, preset an annulled outcome
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    lv_next    = s_level;
                    opa_next   = s_operand;
                    rv_next    = s_read_value;
                    nt_next    = t_reg;
                    nb_next    = b_reg;
                    np_next    = pc_inc;
                    err_next   = ERR_NONE;
                    wv_next    = 1'b0;
                    wval_next  = '0;
                    nl_next    = 1'b0;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                state_next = ST_FIN;
                case (op_reg)
                    OP_LIT: begin
                        if (in_stk(t_p1)) begin
                            mem_we  = 1'b1;
                            mem_wa  = t_p1[SW-1:0];
                            mem_wd  = opa_reg;
                            nt_next = t_p1[SW-1:0];
                        end else begin
                            err_next = ERR_STACK;
                        end
                    end
                    OP_OPR: begin
                        if (opa_reg == OPR_RET) begin
                            if (in_stk(b_m1) && in_stk(b_p2)) begin
                                mem_re     = 1'b1;
                                mem_ra     = b_p1[SW-1:0];
                                state_next = ST_RN_NB;
                            end else begin
                                err_next = ERR_STACK;
                            end
                        end else if (opa_reg == OPR_NEG || opa_reg == OPR_ODD) begin
                            if (in_stk(t_s)) begin
                                mem_re     = 1'b1;
                                mem_ra     = t_reg;
                                state_next = ST_UN_W;
                            end else begin
                                err_next = ERR_STACK;
                            end
                        end else if (opa_reg >= OPR_ADD && opa_reg <= OPR_LE) begin
                            if (t_reg != '0 && in_stk(t_s)) begin
                                mem_re     = 1'b1;
                                mem_ra     = t_reg;
                                state_next = ST_AR_Y;
                            end else begin
                                err_next = ERR_STACK;
                            end
                        end
                    end
                    OP_LOD, OP_STO, OP_CAL: begin
                        base_next  = {{(32-SW){1'b0}}, b_reg};
                        state_next = ST_WALK;
                    end
                    OP_INT: begin
                        if (in_stk(t_pa)) begin
                            nt_next = t_pa[SW-1:0];
                        end else begin
                            err_next = ERR_STACK;
                        end
                    end
                    OP_JMP: begin
                        mod_src_next = opa_reg;
                        state_next   = ST_MOD;
                    end
                    OP_JPC: begin
                        if (t_reg != '0 && in_stk(t_s)) begin
                            mem_re     = 1'b1;
                            mem_ra     = t_reg;
                            nt_next    = t_m1[SW-1:0];
                            state_next = ST_JPC_W;
                        end else begin
                            err_next = ERR_STACK;
                        end
                    end
                    OP_CSP: begin
                        if (opa_reg == CSP_READ) begin
                            if (in_stk(t_p1)) begin
                                mem_we  = 1'b1;
                                mem_wa  = t_p1[SW-1:0];
                                mem_wd  = rv_reg;
                                nt_next = t_p1[SW-1:0];
                            end else begin
                                err_next = ERR_STACK;
                            end
                        end else if (opa_reg == CSP_WRITE) begin
                            if (t_reg != '0 && in_stk(t_s)) begin
                                mem_re     = 1'b1;
                                mem_ra     = t_reg;
                                nt_next    = t_m1[SW-1:0];
                                state_next = ST_CS_W;
                            end else begin
                                err_next = ERR_STACK;
                            end
                        end else if (opa_reg == CSP_WRITELN) begin
                            nl_next = 1'b1;
                        end
                    end
                    OP_RET: begin
                        if (in_stk(t_s) && in_stk(b_m1) && in_stk(b_p2)) begin
                            mem_re     = 1'b1;
                            mem_ra     = b_p1[SW-1:0];
                            state_next = ST_RN_NB;
                        end else begin
                            err_next = ERR_STACK;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // static link walk, one read per level
            ST_WALK: begin
                if (lv_reg == '0) begin
                    state_next = ST_ADDR;
                end else if (in_stk(base_s)) begin
                    mem_re     = 1'b1;
                    mem_ra     = base_reg[SW-1:0];
                    lv_next    = lv_reg - 4'd1;
                    state_next = ST_WALK_W;
                end else begin
                    err_next   = ERR_STACK;
                    state_next = ST_FIN;
                end
            end

            ST_WALK_W: begin
                base_next  = rd_data_reg;
                state_next = ST_WALK;
            end

            // walk finished: LOD, STO or CAL
            ST_ADDR: begin
                state_next = ST_FIN;
                addr_next  = addr_s[SW-1:0];
                case (op_reg)
                    OP_LOD: begin
                        if (in_stk(addr_s) && in_stk(t_p1)) begin
                            mem_re     = 1'b1;
                            mem_ra     = addr_s[SW-1:0];
                            state_next = ST_LOD_W;
                        end else begin
                            err_next = ERR_STACK;
                        end
                    end
                    OP_STO: begin
                        if (in_stk(addr_s) && t_reg != '0 && in_stk(t_s)) begin
                            mem_re     = 1'b1;
                            mem_ra     = t_reg;
                            state_next = ST_STO_W;
                        end else begin
                            err_next = ERR_STACK;
                        end
                    end
                    default: begin
                        if (in_stk(t_p3)) begin
                            mem_we     = 1'b1;
                            mem_wa     = t_p1[SW-1:0];
                            mem_wd     = base_reg;
                            nb_next    = t_p1[SW-1:0];
                            state_next = ST_CAL2;
                        end else begin
                            err_next = ERR_STACK;
                        end
                    end
                endcase
            end

            ST_LOD_W: begin
                mem_we     = 1'b1;
                mem_wa     = t_p1[SW-1:0];
                mem_wd     = rd_data_reg;
                nt_next    = t_p1[SW-1:0];
                state_next = ST_FIN;
            end

            ST_STO_W: begin
                mem_we     = 1'b1;
                mem_wa     = addr_reg;
                mem_wd     = rd_data_reg;
                nt_next    = t_m1[SW-1:0];
                state_next = ST_FIN;
            end

            // call frame: dynamic link, then return address
            ST_CAL2: begin
                mem_we     = 1'b1;
                mem_wa     = t_p2[SW-1:0];
                mem_wd     = {{(32-SW){1'b0}}, b_reg};
                state_next = ST_CAL3;
            end

            ST_CAL3: begin
                mem_we       = 1'b1;
                mem_wa       = t_p3[SW-1:0];
                mem_wd       = {{(32-PCW){1'b0}}, np_reg};
                mod_src_next = opa_reg;
                state_next   = ST_MOD;
            end

            ST_JPC_W: begin
                if (rd_data_reg == '0) begin
                    mod_src_next = opa_reg;
                    state_next   = ST_MOD;
                end else begin
                    state_next = ST_FIN;
                end
            end

            // reduce a target modulo the code depth
            ST_MOD: begin
                if (CODE_POW2) begin
                    np_next    = mod_src_reg[PCW-1:0];
                    state_next = ST_FIN;
                end else begin
                    mq_next    = mod_prod[63:32];
                    state_next = ST_MOD2;
                end
            end

            // estimate is low by at most one divisor
            ST_MOD2: begin
                np_next    = mod_fix[PCW-1:0];
                state_next = ST_FIN;
            end

            // one quotient bit per cycle
            ST_DIVIDE: begin
                dv_rem_next = dv_ge ? dv_sub : dv_sh;
                dv_quo_next = dv_q_fin;
                dv_cnt_next = dv_cnt_reg + 5'd1;
                if (dv_cnt_reg == 5'd31) begin
                    state_next = ST_FIN;
                    mem_we     = 1'b1;
                    mem_wa     = t_m1[SW-1:0];
                    mem_wd     = dv_neg_reg ? (32'd0 - dv_q_fin) : dv_q_fin;
                    nt_next    = t_m1[SW-1:0];
                end
            end

            // return: saved frame base is back
            ST_RN_NB: begin
                if (op_reg == OP_RET) begin
                    if (in_stk(rd_s) && b_ma >= 1 && in_stk(b_ma)) begin
                        nb_next    = rd_data_reg[SW-1:0];
                        nt_next    = b_ma[SW-1:0];
                        addr_next  = b_ma[SW-1:0];
                        mem_re     = 1'b1;
                        mem_ra     = t_reg;
                        state_next = ST_RT_TMP;
                    end else begin
                        err_next   = ERR_STACK;
                        state_next = ST_FIN;
                    end
                end else begin
                    if (in_stk(rd_s)) begin
                        nb_next    = rd_data_reg[SW-1:0];
                        nt_next    = b_m1[SW-1:0];
                        mem_re     = 1'b1;
                        mem_ra     = b_p2[SW-1:0];
                        state_next = ST_RN_PC;
                    end else begin
                        err_next   = ERR_STACK;
                        state_next = ST_FIN;
                    end
                end
            end

            ST_RT_TMP: begin
                d0_next    = rd_data_reg;
                mem_re     = 1'b1;
                mem_ra     = b_p2[SW-1:0];
                state_next = ST_RN_PC;
            end

            // return address is back; value return stores after all reads
            ST_RN_PC: begin
                if (op_reg == OP_RET) begin
                    mem_we = 1'b1;
                    mem_wa = addr_reg;
                    mem_wd = d0_reg;
                end
                mod_src_next = rd_data_reg;
                state_next   = ST_MOD;
            end

            ST_AR_Y: begin
                d0_next    = rd_data_reg;
                mem_re     = 1'b1;
                mem_ra     = t_m1[SW-1:0];
                state_next = ST_AR_X;
            end

            ST_AR_X: begin
                state_next = ST_FIN;
                if (opa_reg == OPR_DIV) begin
                    if (ar_y == '0) begin
                        mem_we   = 1'b1;
                        mem_wa   = t_m1[SW-1:0];
                        mem_wd   = '0;
                        nt_next  = t_m1[SW-1:0];
                        err_next = ERR_DIV0;
                    end else begin
                        dv_rem_next = '0;
                        dv_quo_next = x_abs;
                        dv_den_next = y_abs;
                        dv_cnt_next = '0;
                        dv_neg_next = ar_x[31] ^ ar_y[31];
                        state_next  = ST_DIVIDE;
                    end
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = t_m1[SW-1:0];
                    mem_wd  = ar_res;
                    nt_next = t_m1[SW-1:0];
                end
            end

            ST_UN_W: begin
                mem_we     = 1'b1;
                mem_wa     = t_reg;
                mem_wd     = (opa_reg == OPR_NEG) ? (32'd0 - rd_data_reg)
                                                  : {31'd0, rd_data_reg[0]};
                state_next = ST_FIN;
            end

            ST_CS_W: begin
                wv_next    = 1'b1;
                wval_next  = rd_data_reg;
                state_next = ST_FIN;
            end

            // commit state and hand the result to the output register
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_pc_next    = np_reg;
                    o_wv_next    = wv_reg;
                    o_wval_next  = wval_reg;
                    o_nl_next    = nl_reg;
                    o_err_next   = err_reg;
                    t_next       = nt_reg;
                    b_next       = nb_reg;
                    pc_next      = np_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            t_reg       <= '0;
            b_reg       <= SW'(1);
            pc_reg      <= PCW'(1);
            m_valid_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            b_reg       <= b_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // working and output payload
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        lv_reg      <= lv_next;
        opa_reg     <= opa_next;
        rv_reg      <= rv_next;
        nt_reg      <= nt_next;
        nb_reg      <= nb_next;
        np_reg      <= np_next;
        err_reg     <= err_next;
        wv_reg      <= wv_next;
        wval_reg    <= wval_next;
        nl_reg      <= nl_next;
        base_reg    <= base_next;
        addr_reg    <= addr_next;
        d0_reg      <= d0_next;
        mod_src_reg <= mod_src_next;
        mq_reg      <= mq_next;
        dv_rem_reg  <= dv_rem_next;
        dv_quo_reg  <= dv_quo_next;
        dv_den_reg  <= dv_den_next;
        dv_cnt_reg  <= dv_cnt_next;
        dv_neg_reg  <= dv_neg_next;
        o_pc_reg    <= o_pc_next;
        o_wv_reg    <= o_wv_next;
        o_wval_reg  <= o_wval_next;
        o_nl_reg    <= o_nl_next;
        o_err_reg   <= o_err_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_next_pc     = o_pc_reg;
    assign m_write_valid = o_wv_reg;
    assign m_write_value = $signed(o_wval_reg);
    assign m_newline     = o_nl_reg;
    assign m_halted      = (o_pc_reg == '0);
    assign m_error_code  = o_err_reg;

    // checks
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("stack write while idle");

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted request not decoded");

    a_fault_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code == ERR_STACK) |-> (!m_write_valid && !m_newline))
        else $error("annulled instruction reports i/o");

    a_state_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_FIN) |=> ($stable(t_reg) && $stable(b_reg) && $stable(pc_reg)))
        else $error("machine state changed outside commit");

endmodule
